[sv/tclp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclp_pkg: shared definitions for the command line parser
// Field widths, command codes, bearings and the keyword table that the
// token matchers step through one character at a time.
// ----------------------------------------------------------------------------
package tclp_pkg;

   // Request and response field widths
   localparam int CHAR_W = 8;
   localparam int CMD_W  = 5;
   localparam int ARG_W  = 31;
   localparam int ARG2_W = 9;

   // Default sizing of the token store
   localparam int MAX_TOKENS_DEF  = 4;
   localparam int TOKEN_BYTES_DEF = 12;

   // Only the first four tokens take part in decoding
   localparam int DECODE_SLOTS = 4;

   // Numeric argument: magnitude saturates at 2^31
   localparam int             NUM_W       = 32;
   localparam logic [35:0]    NUM_LIMIT   = 36'h0_8000_0000;
   localparam logic [ARG_W-1:0] RATE_MAX  = 31'h7FFF_FFFF;
   localparam logic [NUM_W-1:0] TOF_INDEX_LIMIT = 32'd64;

   // Character codes
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_TAB    = 8'd9;
   localparam logic [7:0] CH_CR     = 8'd13;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_Z  = 8'h7A;
   localparam logic [7:0] CASE_DIFF = 8'd32;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_NONE       = 5'd0;
   localparam logic [CMD_W-1:0] CMD_UNKNOWN    = 5'd1;
   localparam logic [CMD_W-1:0] CMD_PING       = 5'd2;
   localparam logic [CMD_W-1:0] CMD_STREAM_ON  = 5'd3;
   localparam logic [CMD_W-1:0] CMD_STREAM_OFF = 5'd4;
   localparam logic [CMD_W-1:0] CMD_RATE       = 5'd5;
   localparam logic [CMD_W-1:0] CMD_IMU_ZERO   = 5'd6;
   localparam logic [CMD_W-1:0] CMD_IMU_SAVE   = 5'd7;
   localparam logic [CMD_W-1:0] CMD_CAM_BASE   = 5'd8;
   localparam logic [CMD_W-1:0] CMD_TRI_BASE   = 5'd12;
   localparam logic [CMD_W-1:0] CMD_US_ON      = 5'd16;
   localparam logic [CMD_W-1:0] CMD_US_OFF     = 5'd17;
   localparam logic [CMD_W-1:0] CMD_TOF_SET    = 5'd18;
   localparam logic [CMD_W-1:0] CMD_TOF_POS    = 5'd19;
   localparam logic [CMD_W-1:0] CMD_CFG_SAVE   = 5'd20;
   localparam logic [CMD_W-1:0] CMD_CFG_LOAD   = 5'd21;
   localparam logic [CMD_W-1:0] CMD_CFG_RESET  = 5'd22;

   // Offsets from a sensor group base: first side on/off, second side on/off
   localparam logic [CMD_W-1:0] OFS_A_ON  = 5'd0;
   localparam logic [CMD_W-1:0] OFS_A_OFF = 5'd1;
   localparam logic [CMD_W-1:0] OFS_B_ON  = 5'd2;
   localparam logic [CMD_W-1:0] OFS_B_OFF = 5'd3;

   // Bearings for sensor placement
   localparam logic [ARG2_W-1:0] BEARING_FRONT = 9'd0;
   localparam logic [ARG2_W-1:0] BEARING_RIGHT = 9'd90;
   localparam logic [ARG2_W-1:0] BEARING_BACK  = 9'd180;
   localparam logic [ARG2_W-1:0] BEARING_LEFT  = 9'd270;

   // Keyword indexes
   localparam int KW_PING   = 0;
   localparam int KW_STREAM = 1;
   localparam int KW_RATE   = 2;
   localparam int KW_IMU    = 3;
   localparam int KW_CAM    = 4;
   localparam int KW_TRIPLE = 5;
   localparam int KW_US     = 6;
   localparam int KW_TOF    = 7;
   localparam int KW_CFG    = 8;
   localparam int KW_ON     = 9;
   localparam int KW_OFF    = 10;
   localparam int KW_ZERO   = 11;
   localparam int KW_SAVE   = 12;
   localparam int KW_F      = 13;
   localparam int KW_B      = 14;
   localparam int KW_L      = 15;
   localparam int KW_R      = 16;
   localparam int KW_LOAD   = 17;
   localparam int KW_RESET  = 18;
   localparam int KW_POS    = 19;
   localparam int KW_FRONT  = 20;
   localparam int KW_RIGHT  = 21;
   localparam int KW_BACK   = 22;
   localparam int KW_LEFT   = 23;
   localparam int KW_COUNT  = 24;
   localparam int KW_MAX    = 8;

   typedef logic [KW_COUNT-1:0] kw_mask_type;

   // Keyword text, right-justified: first character in the highest used byte
   localparam logic [KW_MAX*8-1:0] KW_TEXT [KW_COUNT] = '{
      "PING", "STREAM", "RATE", "IMU", "CAM", 64'h0042_4E4F, "US", "TOF", "CFG",
      "ON", "OFF", "ZERO", "SAVE", "F", "B", "L", "R", "LOAD", "RESET",
      "POS", "FRONT", "RIGHT", "BACK", "LEFT"
   };

   localparam int KW_LEN [KW_COUNT] = '{
      4, 6, 4, 3, 3, 3, 2, 3, 3,
      2, 3, 4, 4, 1, 1, 1, 1, 4, 5,
      3, 5, 5, 4, 4
   };

   // True when character c at position pos continues keyword k
   function automatic logic kw_step(input int k, input int pos, input logic [7:0] c);
      logic hit;
      hit = 1'b0;
      if (pos < KW_LEN[k]) begin
         hit = (KW_TEXT[k][8*(KW_LEN[k]-1-pos) +: 8] == c);
      end
      return hit;
   endfunction

endpackage

[sv/tclp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclp_if: request and response channels of the command line parser
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tclp_req_if;
   logic                        valid;
   logic                        ready;
   logic [tclp_pkg::CHAR_W-1:0] char_code;
   logic                        has_char;
   logic                        line_end;

   modport source (output valid, output char_code, output has_char,
                   output line_end, input ready);
   modport sink   (input valid, input char_code, input has_char,
                   input line_end, output ready);
endinterface

interface tclp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tclp_pkg::CMD_W-1:0]  command;
   logic [tclp_pkg::ARG_W-1:0]  argument;
   logic [tclp_pkg::ARG2_W-1:0] argument_two;

   modport source (output valid, output command, output argument,
                   output argument_two, input ready);
   modport sink   (input valid, input command, input argument,
                   input argument_two, output ready);
endinterface

[sv/text_command_line_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_command_line_parser: console command line tokenizer and decoder
// A line's response is registered: the line-end byte passes the input register,
// then token update and decode fill the response register (a held response stalls it).
// Throughput: one byte per cycle; only a held response stalls the request side.
// Keyword matching and number accumulation advance one character per cycle.
// Reset: synchronous, active high; clears the token state and both valids.
// ----------------------------------------------------------------------------
module text_command_line_parser #(
   parameter int MAX_TOKENS  = tclp_pkg::MAX_TOKENS_DEF,
   parameter int TOKEN_BYTES = tclp_pkg::TOKEN_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tclp_req_if.sink    req_chan,
   tclp_rsp_if.source  rsp_chan
);

   localparam int TOKEN_CHARS = TOKEN_BYTES - 1;
   localparam int CNT_W       = $clog2(MAX_TOKENS + 1);
   localparam int LEN_W       = $clog2(TOKEN_BYTES);
   localparam int SLOTS       = tclp_pkg::DECODE_SLOTS;

   typedef logic [LEN_W-1:0] len_type;

   // Input register
   logic                        in_valid_ff;
   logic [tclp_pkg::CHAR_W-1:0] in_char_ff;
   logic                        in_has_ff;
   logic                        in_end_ff;

   // Token state
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  inside_ff, inside_in;
   len_type               len_ff   [SLOTS];
   len_type               len_in   [SLOTS];
   tclp_pkg::kw_mask_type match_ff [SLOTS];
   tclp_pkg::kw_mask_type match_in [SLOTS];

   // Number accumulator for the second token
   logic                        num_neg_ff, num_neg_in;
   logic                        num_bad_ff, num_bad_in;
   logic                        num_digit_ff, num_digit_in;
   logic [tclp_pkg::NUM_W-1:0]  num_mag_ff, num_mag_in;

   // Response register
   logic                        rsp_valid_ff;
   logic [tclp_pkg::CMD_W-1:0]  rsp_cmd_ff, rsp_cmd_in;
   logic [tclp_pkg::ARG_W-1:0]  rsp_arg_ff, rsp_arg_in;
   logic [tclp_pkg::ARG2_W-1:0] rsp_arg2_ff, rsp_arg2_in;

   logic                  out_free;
   logic                  advance;
   logic                  is_sep;
   logic [7:0]            up_char;
   logic                  is_digit;
   logic [CNT_W-1:0]      write_slot;
   logic [35:0]           mag_next;
   tclp_pkg::kw_mask_type hit [SLOTS];
   logic                  num_ok;
   logic                  at_least2, at_least3, at_least4;
   logic                  side_on, side_off;

   // Handshake: hold a line-end item in the input register until the response slot frees
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && (!in_end_ff || out_free);
   assign req_chan.ready = !in_valid_ff || advance;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.command      = rsp_cmd_ff;
   assign rsp_chan.argument     = rsp_arg_ff;
   assign rsp_chan.argument_two = rsp_arg2_ff;

   // Classify and upper-case the registered byte
   always_comb begin
      is_sep = (in_char_ff == tclp_pkg::CH_SPACE) || (in_char_ff == tclp_pkg::CH_COMMA) ||
               ((in_char_ff >= tclp_pkg::CH_TAB) && (in_char_ff <= tclp_pkg::CH_CR));
      if ((in_char_ff >= tclp_pkg::CH_LOW_A) && (in_char_ff <= tclp_pkg::CH_LOW_Z)) begin
         up_char = in_char_ff - tclp_pkg::CASE_DIFF;
      end else begin
         up_char = in_char_ff;
      end
      is_digit = (up_char >= tclp_pkg::CH_ZERO) && (up_char <= tclp_pkg::CH_NINE);
   end

   // Advance the token state by one byte
   always_comb begin
      count_in     = count_ff;
      inside_in    = inside_ff;
      len_in       = len_ff;
      match_in     = match_ff;
      num_neg_in   = num_neg_ff;
      num_bad_in   = num_bad_ff;
      num_digit_in = num_digit_ff;
      num_mag_in   = num_mag_ff;
      mag_next     = ({4'b0, num_mag_ff} << 3) + ({4'b0, num_mag_ff} << 1) +
                     36'(up_char - tclp_pkg::CH_ZERO);
      write_slot   = count_ff;

      if (in_has_ff) begin
         if (is_sep) begin
            inside_in = 1'b0;
         end else begin
            // open a new token while slots remain
            if (!inside_ff && (count_ff < CNT_W'(MAX_TOKENS))) begin
               count_in  = count_ff + CNT_W'(1);
               inside_in = 1'b1;
               for (int s = 0; s < SLOTS; s++) begin
                  if (count_ff == CNT_W'(s)) begin
                     len_in[s]   = '0;
                     match_in[s] = '1;
                  end
               end
               if (count_ff == CNT_W'(1)) begin
                  num_neg_in   = 1'b0;
                  num_bad_in   = 1'b0;
                  num_digit_in = 1'b0;
                  num_mag_in   = '0;
               end
            end
            // append the character to the open token, dropping past the limit
            if (inside_in) begin
               write_slot = count_in - CNT_W'(1);
               for (int s = 0; s < SLOTS; s++) begin
                  if ((write_slot == CNT_W'(s)) && (len_in[s] < LEN_W'(TOKEN_CHARS))) begin
                     for (int k = 0; k < tclp_pkg::KW_COUNT; k++) begin
                        match_in[s][k] = match_in[s][k] &&
                                         tclp_pkg::kw_step(k, int'(len_in[s]), up_char);
                     end
                     if (s == 1) begin
                        if ((len_in[s] == '0) && ((up_char == tclp_pkg::CH_PLUS) ||
                                                  (up_char == tclp_pkg::CH_MINUS))) begin
                           num_neg_in = (up_char == tclp_pkg::CH_MINUS);
                        end else if (is_digit) begin
                           num_digit_in = 1'b1;
                           if (mag_next > tclp_pkg::NUM_LIMIT) begin
                              num_mag_in = tclp_pkg::NUM_LIMIT[tclp_pkg::NUM_W-1:0];
                           end else begin
                              num_mag_in = mag_next[tclp_pkg::NUM_W-1:0];
                           end
                        end else begin
                           num_bad_in = 1'b1;
                        end
                     end
                     len_in[s] = len_in[s] + LEN_W'(1);
                  end
               end
            end
         end
      end
   end

   // Exact keyword hits on the updated tokens
   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         for (int k = 0; k < tclp_pkg::KW_COUNT; k++) begin
            hit[s][k] = match_in[s][k] && (len_in[s] == LEN_W'(tclp_pkg::KW_LEN[k]));
         end
      end
   end

   // Decode the line into a command and its arguments
   always_comb begin
      num_ok    = num_digit_in && !num_bad_in;
      at_least2 = count_in >= CNT_W'(2);
      at_least3 = count_in >= CNT_W'(3);
      at_least4 = count_in >= CNT_W'(4);
      side_on   = hit[2][tclp_pkg::KW_ON];
      side_off  = hit[2][tclp_pkg::KW_OFF];

      rsp_cmd_in  = tclp_pkg::CMD_NONE;
      rsp_arg_in  = '0;
      rsp_arg2_in = '0;

      if (count_in != '0) begin
         rsp_cmd_in = tclp_pkg::CMD_UNKNOWN;
         if (hit[0][tclp_pkg::KW_PING]) begin
            rsp_cmd_in = tclp_pkg::CMD_PING;
         end else if (hit[0][tclp_pkg::KW_STREAM]) begin
            if (at_least2 && hit[1][tclp_pkg::KW_ON]) begin
               rsp_cmd_in = tclp_pkg::CMD_STREAM_ON;
            end else if (at_least2 && hit[1][tclp_pkg::KW_OFF]) begin
               rsp_cmd_in = tclp_pkg::CMD_STREAM_OFF;
            end
         end else if (hit[0][tclp_pkg::KW_RATE]) begin
            if (at_least2 && num_ok && !num_neg_in && (num_mag_in != '0)) begin
               rsp_cmd_in = tclp_pkg::CMD_RATE;
               if (num_mag_in[tclp_pkg::NUM_W-1]) begin
                  rsp_arg_in = tclp_pkg::RATE_MAX;
               end else begin
                  rsp_arg_in = num_mag_in[tclp_pkg::ARG_W-1:0];
               end
            end
         end else if (hit[0][tclp_pkg::KW_IMU]) begin
            if (at_least2 && hit[1][tclp_pkg::KW_ZERO]) begin
               rsp_cmd_in = tclp_pkg::CMD_IMU_ZERO;
            end else if (at_least2 && hit[1][tclp_pkg::KW_SAVE]) begin
               rsp_cmd_in = tclp_pkg::CMD_IMU_SAVE;
            end
         end else if (hit[0][tclp_pkg::KW_CAM]) begin
            if (at_least3 && (side_on || side_off)) begin
               if (hit[1][tclp_pkg::KW_F]) begin
                  rsp_cmd_in = tclp_pkg::CMD_CAM_BASE +
                               (side_on ? tclp_pkg::OFS_A_ON : tclp_pkg::OFS_A_OFF);
               end else if (hit[1][tclp_pkg::KW_B]) begin
                  rsp_cmd_in = tclp_pkg::CMD_CAM_BASE +
                               (side_on ? tclp_pkg::OFS_B_ON : tclp_pkg::OFS_B_OFF);
               end
            end
         end else if (hit[0][tclp_pkg::KW_TRIPLE]) begin
            if (at_least3 && (side_on || side_off)) begin
               if (hit[1][tclp_pkg::KW_L]) begin
                  rsp_cmd_in = tclp_pkg::CMD_TRI_BASE +
                               (side_on ? tclp_pkg::OFS_A_ON : tclp_pkg::OFS_A_OFF);
               end else if (hit[1][tclp_pkg::KW_R]) begin
                  rsp_cmd_in = tclp_pkg::CMD_TRI_BASE +
                               (side_on ? tclp_pkg::OFS_B_ON : tclp_pkg::OFS_B_OFF);
               end
            end
         end else if (hit[0][tclp_pkg::KW_US]) begin
            if (at_least2 && hit[1][tclp_pkg::KW_ON]) begin
               rsp_cmd_in = tclp_pkg::CMD_US_ON;
            end else if (at_least2 && hit[1][tclp_pkg::KW_OFF]) begin
               rsp_cmd_in = tclp_pkg::CMD_US_OFF;
            end
         end else if (hit[0][tclp_pkg::KW_TOF]) begin
            // index 0..63, a negative sign allowed only on zero
            if (at_least3 && num_ok && (!num_neg_in || (num_mag_in == '0)) &&
                (num_mag_in < tclp_pkg::TOF_INDEX_LIMIT)) begin
               if (side_on || side_off) begin
                  rsp_cmd_in  = tclp_pkg::CMD_TOF_SET;
                  rsp_arg_in  = tclp_pkg::ARG_W'(num_mag_in[5:0]);
                  rsp_arg2_in = tclp_pkg::ARG2_W'(side_on);
               end else if (hit[2][tclp_pkg::KW_POS] && at_least4) begin
                  if (hit[3][tclp_pkg::KW_FRONT] || hit[3][tclp_pkg::KW_RIGHT] ||
                      hit[3][tclp_pkg::KW_BACK]  || hit[3][tclp_pkg::KW_LEFT]) begin
                     rsp_cmd_in = tclp_pkg::CMD_TOF_POS;
                     rsp_arg_in = tclp_pkg::ARG_W'(num_mag_in[5:0]);
                  end
                  if (hit[3][tclp_pkg::KW_FRONT]) begin
                     rsp_arg2_in = tclp_pkg::BEARING_FRONT;
                  end else if (hit[3][tclp_pkg::KW_RIGHT]) begin
                     rsp_arg2_in = tclp_pkg::BEARING_RIGHT;
                  end else if (hit[3][tclp_pkg::KW_BACK]) begin
                     rsp_arg2_in = tclp_pkg::BEARING_BACK;
                  end else if (hit[3][tclp_pkg::KW_LEFT]) begin
                     rsp_arg2_in = tclp_pkg::BEARING_LEFT;
                  end
               end
            end
         end else if (hit[0][tclp_pkg::KW_CFG]) begin
            if (at_least2 && hit[1][tclp_pkg::KW_SAVE]) begin
               rsp_cmd_in = tclp_pkg::CMD_CFG_SAVE;
            end else if (at_least2 && hit[1][tclp_pkg::KW_LOAD]) begin
               rsp_cmd_in = tclp_pkg::CMD_CFG_LOAD;
            end else if (at_least2 && hit[1][tclp_pkg::KW_RESET]) begin
               rsp_cmd_in = tclp_pkg::CMD_CFG_RESET;
            end
         end
      end
   end

   // Control state: valids, token count, open-token flag, number accumulator, lengths and matches
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         inside_ff    <= 1'b0;
         num_neg_ff   <= 1'b0;
         num_bad_ff   <= 1'b0;
         num_digit_ff <= 1'b0;
         num_mag_ff   <= '0;
         for (int s = 0; s < SLOTS; s++) begin
            len_ff[s]   <= '0;
            match_ff[s] <= '1;
         end
      end else begin
         // take a request whenever the input register is free or moving on
         if (req_chan.valid && req_chan.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance && in_end_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // commit the byte, or clear for the next line at its end
         if (advance) begin
            if (in_end_ff) begin
               count_ff     <= '0;
               inside_ff    <= 1'b0;
               num_neg_ff   <= 1'b0;
               num_bad_ff   <= 1'b0;
               num_digit_ff <= 1'b0;
               num_mag_ff   <= '0;
               for (int s = 0; s < SLOTS; s++) begin
                  len_ff[s]   <= '0;
                  match_ff[s] <= '1;
               end
            end else begin
               count_ff     <= count_in;
               inside_ff    <= inside_in;
               num_neg_ff   <= num_neg_in;
               num_bad_ff   <= num_bad_in;
               num_digit_ff <= num_digit_in;
               num_mag_ff   <= num_mag_in;
               len_ff       <= len_in;
               match_ff     <= match_in;
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_char_ff <= req_chan.char_code;
         in_has_ff  <= req_chan.has_char;
         in_end_ff  <= req_chan.line_end;
      end
      if (advance && in_end_ff) begin
         rsp_cmd_ff  <= rsp_cmd_in;
         rsp_arg_ff  <= rsp_arg_in;
         rsp_arg2_ff <= rsp_arg2_in;
      end
   end

endmodule
